// ===== hdl/matrix_multiply_3x3_macros.svh =====
// Assertion macros shared by the matrix multiply RTL.
`ifndef MATRIX_MULTIPLY_3X3_MACROS_SVH
`define MATRIX_MULTIPLY_3X3_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MM3_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MM3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MM3_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define MM3_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/mm3_pkg.sv =====
// Shared types and constants for the matrix multiply block.
`timescale 1ns / 1ps

package mm3_pkg;

   // Fixed field widths of the request and response channels
   localparam int VALUE_BITS = 16;
   localparam int PROD_BITS  = 34;
   localparam int COORD_BITS = 2;

   typedef logic [1:0] func_type;

   localparam func_type FUNC_LOAD_LEFT  = 2'd0;
   localparam func_type FUNC_LOAD_RIGHT = 2'd1;
   localparam func_type FUNC_COMPUTE    = 2'd2;

   typedef logic        [COORD_BITS-1:0] coord_type;
   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   // Control part of a token moving along the cell chain
   typedef struct packed {
      logic valid;
      logic last;
   } tok_ctl_type;

   // Which stored matrix a load writes
   typedef struct packed {
      logic left;
      logic right;
   } wr_ctl_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } seq_state_type;

endpackage

// ===== hdl/mm3_cell.sv =====
// One multiply-accumulate cell: holds one left column and one right row.
`timescale 1ns / 1ps

module mm3_cell #(
   parameter int DIM       = 3,
   parameter int ELEM_BITS = 16,
   parameter int CELL_IDX  = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  mm3_pkg::wr_ctl_type         wr_ctl,
   input  logic [$clog2(DIM)-1:0]      wr_row,
   input  logic [$clog2(DIM)-1:0]      wr_col,
   input  logic signed [ELEM_BITS-1:0] wr_data,
   input  mm3_pkg::tok_ctl_type        ctl_in,
   input  logic [$clog2(DIM)-1:0]      row_in,
   input  logic [$clog2(DIM)-1:0]      col_in,
   input  mm3_pkg::prod_type           psum_in,
   output mm3_pkg::tok_ctl_type        ctl_out,
   output logic [$clog2(DIM)-1:0]      row_out,
   output logic [$clog2(DIM)-1:0]      col_out,
   output mm3_pkg::prod_type           psum_out
);
   import mm3_pkg::*;

   localparam int IDX_W = $clog2(DIM);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   typedef logic signed [ELEM_BITS-1:0]   elem_type;
   typedef logic signed [2*ELEM_BITS-1:0] mul_type;

   // left column CELL_IDX (indexed by row) and right row CELL_IDX (indexed by column)
   elem_type lcol_ff [DIM];
   elem_type rrow_ff [DIM];

   elem_type lft_op;
   elem_type rgt_op;
   mul_type  mul_full;

   tok_ctl_type      ctl_a_ff;
   tok_ctl_type      ctl_b_ff;
   logic [IDX_W-1:0] row_a_ff;
   logic [IDX_W-1:0] col_a_ff;
   logic [IDX_W-1:0] row_b_ff;
   logic [IDX_W-1:0] col_b_ff;
   prod_type         psum_a_ff;
   prod_type         prod_a_ff;
   prod_type         psum_b_ff;

   // element loads
   always_ff @(posedge clock) begin
      if (wr_ctl.left && wr_col == MY_IDX) begin
         lcol_ff[wr_row] <= wr_data;
      end
      if (wr_ctl.right && wr_row == MY_IDX) begin
         rrow_ff[wr_col] <= wr_data;
      end
   end

   // operand select and full-width signed product
   assign lft_op   = lcol_ff[row_in];
   assign rgt_op   = rrow_ff[col_in];
   assign mul_full = mul_type'(lft_op) * mul_type'(rgt_op);

   // token valid and last bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
      end else if (advance) begin
         ctl_a_ff <= ctl_in;
         ctl_b_ff <= ctl_a_ff;
      end
   end

   // stage a registers the product, stage b adds it to the running sum
   always_ff @(posedge clock) begin
      if (advance) begin
         row_a_ff  <= row_in;
         col_a_ff  <= col_in;
         psum_a_ff <= psum_in;
         prod_a_ff <= prod_type'(mul_full);
         row_b_ff  <= row_a_ff;
         col_b_ff  <= col_a_ff;
         psum_b_ff <= psum_a_ff + prod_a_ff;
      end
   end

   assign ctl_out  = ctl_b_ff;
   assign row_out  = row_b_ff;
   assign col_out  = col_b_ff;
   assign psum_out = psum_b_ff;

endmodule

// ===== hdl/matrix_multiply_3x3.sv =====
// Top level of the DIM x DIM integer matrix multiply: sequencer and cell chain.
//
//   channel | direction | ports                                          | transfer
//   --------+-----------+------------------------------------------------+-------------------
//   req     | in        | req_func, req_row, req_col, req_value          | req_valid & ready
//   rsp     | out       | rsp_out_row, rsp_out_col, rsp_product, rsp_last| rsp_valid & ready
//
// A load is written when it transfers; loads may follow each other in every cycle.
// A compute issues DIM*DIM tokens, one per cycle while the response is not stalled, into a chain
// of DIM cells of two stages each; results leave the last cell's second stage one per cycle while not stalled.
// The next request is taken in the cycle after the last result transfers.
// A stalled response freezes the whole chain. Reset clears the sequencer and valid bits;
// stored matrix entries are undefined until loaded.
`timescale 1ns / 1ps
`include "matrix_multiply_3x3_macros.svh"

module matrix_multiply_3x3 #(
   parameter int DIM       = 3,
   parameter int ELEM_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mm3_pkg::func_type    req_func,
   input  mm3_pkg::coord_type   req_row,
   input  mm3_pkg::coord_type   req_col,
   input  mm3_pkg::value_type   req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mm3_pkg::coord_type   rsp_out_row,
   output mm3_pkg::coord_type   rsp_out_col,
   output mm3_pkg::prod_type    rsp_product,
   output logic                 rsp_last
);
   import mm3_pkg::*;

   localparam int IDX_W = $clog2(DIM);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

   typedef logic signed [ELEM_BITS-1:0] elem_type;

   seq_state_type    state_ff;
   seq_state_type    state_in;
   logic [IDX_W-1:0] irow_ff;
   logic [IDX_W-1:0] irow_in;
   logic [IDX_W-1:0] icol_ff;
   logic [IDX_W-1:0] icol_in;

   logic advance;
   logic req_xfer;
   logic rsp_xfer;
   logic issue;
   logic issue_last;
   logic idx_ok;

   wr_ctl_type       wr_ctl;
   logic [IDX_W-1:0] wr_row;
   logic [IDX_W-1:0] wr_col;
   elem_type         wr_data;

   tok_ctl_type      ctl_chain  [DIM+1];
   logic [IDX_W-1:0] row_chain  [DIM+1];
   logic [IDX_W-1:0] col_chain  [DIM+1];
   prod_type         psum_chain [DIM+1];

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign advance   = !rsp_valid || rsp_ready;

   // load decode; out-of-range coordinates are dropped
   assign idx_ok       = (int'(req_row) < DIM) && (int'(req_col) < DIM);
   assign wr_ctl.left  = req_xfer && (req_func == FUNC_LOAD_LEFT) && idx_ok;
   assign wr_ctl.right = req_xfer && (req_func == FUNC_LOAD_RIGHT) && idx_ok;
   assign wr_row       = IDX_W'(req_row);
   assign wr_col       = IDX_W'(req_col);
   assign wr_data      = elem_type'(req_value);

   // sequencer: walk the result elements in row-major order
   assign issue      = (state_ff == ST_ISSUE) && advance;
   assign issue_last = (irow_ff == LAST_IDX) && (icol_ff == LAST_IDX);

   always_comb begin
      state_in = state_ff;
      irow_in  = irow_ff;
      icol_in  = icol_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_func == FUNC_COMPUTE) begin
               state_in = ST_ISSUE;
               irow_in  = '0;
               icol_in  = '0;
            end
         end
         ST_ISSUE: begin
            if (advance) begin
               if (icol_ff == LAST_IDX) begin
                  icol_in = '0;
                  if (irow_ff == LAST_IDX) begin
                     state_in = ST_DRAIN;
                  end else begin
                     irow_in = irow_ff + 1'b1;
                  end
               end else begin
                  icol_in = icol_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_xfer && rsp_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         irow_ff  <= '0;
         icol_ff  <= '0;
      end else begin
         state_ff <= state_in;
         irow_ff  <= irow_in;
         icol_ff  <= icol_in;
      end
   end

   // head of the chain
   assign ctl_chain[0].valid = issue;
   assign ctl_chain[0].last  = issue_last;
   assign row_chain[0]       = irow_ff;
   assign col_chain[0]       = icol_ff;
   assign psum_chain[0]      = '0;

   // cell k adds left[i][k] * right[k][j]
   for (genvar k = 0; k < DIM; k++) begin : g_cell
      mm3_cell #(
         .DIM       (DIM),
         .ELEM_BITS (ELEM_BITS),
         .CELL_IDX  (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .wr_ctl   (wr_ctl),
         .wr_row   (wr_row),
         .wr_col   (wr_col),
         .wr_data  (wr_data),
         .ctl_in   (ctl_chain[k]),
         .row_in   (row_chain[k]),
         .col_in   (col_chain[k]),
         .psum_in  (psum_chain[k]),
         .ctl_out  (ctl_chain[k+1]),
         .row_out  (row_chain[k+1]),
         .col_out  (col_chain[k+1]),
         .psum_out (psum_chain[k+1])
      );
   end

   // last cell's second stage is the response register
   assign rsp_valid   = ctl_chain[DIM].valid;
   assign rsp_last    = ctl_chain[DIM].last;
   assign rsp_out_row = COORD_BITS'(row_chain[DIM]);
   assign rsp_out_col = COORD_BITS'(col_chain[DIM]);
   assign rsp_product = psum_chain[DIM];

   // checks
   `MM3_ASSERT_IMPL(a_busy_while_rsp, clock, reset, rsp_valid, !req_ready, "request taken during compute")
   `MM3_ASSERT_NEXT(a_compute_blocks, clock, reset, req_xfer && req_func == FUNC_COMPUTE, !req_ready, "compute did not start")
   `MM3_ASSERT_NEXT(a_last_frees, clock, reset, rsp_xfer && rsp_last, req_ready, "not idle after last result")
   `MM3_ASSERT_IMPL(a_last_coord, clock, reset, rsp_valid && rsp_last, rsp_out_row == COORD_BITS'(DIM - 1) && rsp_out_col == COORD_BITS'(DIM - 1), "last mark on wrong element")

endmodule
